// File: src/arp_pkg.sv
// Shared types and constants for the AT response parser.
// Holds recognizer state codes, status codes, register indexes and the
// state and result structs passed between the step logic and the top level.
package arp_pkg;

  // Line store geometry.
  localparam int LINE_LEN   = 128;
  localparam int LINE_SLOTS = 16;
  localparam int COL_W      = $clog2(LINE_LEN + 1);
  localparam int LINE_W     = $clog2(LINE_SLOTS + 1);

  // Characters the recognizer looks for.
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_K    = 8'h4B;
  localparam logic [7:0] CH_R    = 8'h52;

  // Result status codes.
  localparam logic [1:0] STATUS_BUSY  = 2'd0;
  localparam logic [1:0] STATUS_DONE  = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  // Configuration register map.
  localparam int          APB_ADDR_W       = 3;
  localparam logic [0:0]  REG_SPECIAL_MODE = 1'b0;

  // Recognizer states; the numeric code is reported on a syntax error.
  typedef enum logic [4:0] {
    ST_IDLE       = 5'd0,
    ST_LF1        = 5'd1,
    ST_FIRST      = 5'd2,
    ST_E1_R1      = 5'd3,
    ST_E1_R2      = 5'd4,
    ST_E1_O       = 5'd5,
    ST_E1_R3      = 5'd6,
    ST_FINAL_CR   = 5'd7,
    ST_FINAL_LF   = 5'd8,
    ST_DONE       = 5'd9,
    ST_O1_K       = 5'd10,
    ST_TEXT       = 5'd11,
    ST_TEXT_LF    = 5'd12,
    ST_LINE_START = 5'd13,
    ST_BLANK_LF   = 5'd14,
    ST_RESULT     = 5'd15,
    ST_O2_K       = 5'd16,
    ST_E2_R1      = 5'd17,
    ST_E2_R2      = 5'd18,
    ST_E2_O       = 5'd19,
    ST_E2_R3      = 5'd20
  } arp_fsm_t;

  // Architectural state carried from byte to byte.
  typedef struct packed {
    arp_fsm_t          fsm;
    logic [LINE_W-1:0] line_pos;
    logic [COL_W-1:0]  column_pos;
    logic              ok_flag;
    logic [LINE_W-1:0] lines_stored;
  } arp_state_t;

  // One result per byte.
  typedef struct packed {
    logic [1:0] status;
    logic [4:0] error_state;
    logic       response_ok;
    logic [4:0] text_lines;
    logic       write_valid;
    logic [3:0] write_line;
    logic [7:0] write_col;
    logic [7:0] write_char;
  } arp_result_t;

endpackage

// File: src/at_response_parser_core.sv
// AT response parser top level: input register, step logic, result register.
// Each byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle unless stalled; recognizer state updates in one step.
// Reset (rst, synchronous): idle state, counters cleared, special_mode 0.
// Depends on arp_pkg, arp_cfg and arp_step.
module at_response_parser_core
  import arp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // Byte input channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            data_byte,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [4:0]            error_state,
  output logic                  response_ok,
  output logic [4:0]            text_lines,
  output logic                  write_valid,
  output logic [3:0]            write_line,
  output logic [7:0]            write_col,
  output logic [7:0]            write_char
);

  logic        special_mode;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        advance;
  arp_state_t  state_q;
  arp_state_t  state_next;
  arp_result_t res_next;
  arp_result_t res_q;

  arp_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .special_mode (special_mode)
  );

  arp_step u_step (
    .cur          (state_q),
    .data_byte    (s1_byte),
    .special_mode (special_mode),
    .nxt          (state_next),
    .res          (res_next)
  );

  // The held byte moves on whenever the result register is free or draining.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= data_byte;
    end
  end

  // Recognizer state, updated once per processed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state_q <= '{fsm: ST_IDLE, line_pos: '0, column_pos: '0,
                   ok_flag: 1'b0, lines_stored: '0};
    end else if (advance) begin
      state_q <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign status      = res_q.status;
  assign error_state = res_q.error_state;
  assign response_ok = res_q.response_ok;
  assign text_lines  = res_q.text_lines;
  assign write_valid = res_q.write_valid;
  assign write_line  = res_q.write_line;
  assign write_col   = res_q.write_col;
  assign write_char  = res_q.write_char;

`ifndef SYNTHESIS
  // Once complete, the recognizer stays complete until reset.
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    (state_q.fsm == ST_DONE) |=> (state_q.fsm == ST_DONE))
    else $error("parser left the completed state");

  // A syntax error names a nonzero state and never writes the line store.
  a_error_report: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_ERROR) |-> (error_state != 5'd0 && !write_valid))
    else $error("bad error report");

  // Without an error the error state field is zero.
  a_no_error_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_ERROR) |-> (error_state == 5'd0))
    else $error("error state set without error");

  // Line count saturates and writes stay inside the store.
  a_store_bounds: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (text_lines <= 5'(LINE_SLOTS) &&
                   (!write_valid || write_col <= 8'(LINE_LEN))))
    else $error("line store bounds exceeded");
`endif

endmodule

// File: src/arp_cfg.sv
// APB-style configuration register block for the AT response parser.
// Depends on arp_pkg for the register map.
module arp_cfg
  import arp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic                  special_mode
);

  logic reg_hit;

  // Word index decode; the low two address bits select a byte lane only.
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_SPECIAL_MODE);
  assign pready  = 1'b1;

  // Register write on the access phase of a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      special_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      special_mode <= pwdata[0];
    end
  end

  // Read data mux.
  always_comb begin
    prdata = 32'd0;
    if (reg_hit) begin
      prdata = {31'd0, special_mode};
    end
  end

endmodule

// File: src/arp_step.sv
// Next-state and result logic for one received byte of an AT response.
// Purely combinational; depends on arp_pkg for states, codes and structs.
module arp_step
  import arp_pkg::*;
(
  input  arp_state_t  cur,
  input  logic [7:0]  data_byte,
  input  logic        special_mode,
  output arp_state_t  nxt,
  output arp_result_t res
);

  logic     line_free;
  logic     can_put;
  logic     err;
  arp_fsm_t fsm_next;

  assign line_free = (cur.line_pos < LINE_W'(LINE_SLOTS));
  assign can_put   = line_free && (cur.column_pos < COL_W'(LINE_LEN));

  // Transition and line-store write for the current byte.
  always_comb begin
    nxt              = cur;
    fsm_next         = cur.fsm;
    err              = 1'b0;
    res              = '0;
    res.write_valid  = 1'b0;

    unique case (cur.fsm)
      ST_IDLE: begin
        if (data_byte == CH_CR) fsm_next = ST_LF1;
      end
      ST_LF1: begin
        if (data_byte == CH_LF) fsm_next = ST_FIRST;
        else err = 1'b1;
      end
      ST_FIRST: begin
        if (special_mode) begin
          if (data_byte != CH_CR && data_byte != CH_PLUS) begin
            // First text character of an unprefixed line.
            if (can_put) begin
              res.write_valid = 1'b1;
              res.write_line  = 4'(cur.line_pos);
              res.write_col   = 8'(cur.column_pos);
              res.write_char  = data_byte;
              nxt.column_pos  = COL_W'(cur.column_pos + 1'b1);
            end
            fsm_next = ST_TEXT;
          end else begin
            err = 1'b1;
          end
        end else if (data_byte == CH_E) begin
          fsm_next = ST_E1_R1;
        end else if (data_byte == CH_O) begin
          fsm_next = ST_O1_K;
        end else if (data_byte == CH_PLUS) begin
          fsm_next = ST_TEXT;
        end else begin
          err = 1'b1;
        end
      end
      ST_E1_R1: begin
        if (data_byte == CH_R) fsm_next = ST_E1_R2;
        else err = 1'b1;
      end
      ST_E1_R2: begin
        if (data_byte == CH_R) fsm_next = ST_E1_O;
        else err = 1'b1;
      end
      ST_E1_O: begin
        if (data_byte == CH_O) fsm_next = ST_E1_R3;
        else err = 1'b1;
      end
      ST_E1_R3, ST_E2_R3: begin
        if (data_byte == CH_R) begin
          fsm_next    = ST_FINAL_CR;
          nxt.ok_flag = 1'b0;
        end else begin
          err = 1'b1;
        end
      end
      ST_FINAL_CR: begin
        if (data_byte == CH_CR) fsm_next = ST_FINAL_LF;
        else err = 1'b1;
      end
      ST_FINAL_LF: begin
        if (data_byte == CH_LF) fsm_next = ST_DONE;
        else err = 1'b1;
      end
      ST_DONE: begin
        fsm_next = ST_DONE;
      end
      ST_O1_K, ST_O2_K: begin
        if (data_byte == CH_K) begin
          fsm_next    = ST_FINAL_CR;
          nxt.ok_flag = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      ST_TEXT: begin
        if (data_byte != CH_CR) begin
          // Text character; dropped once the line or the store is full.
          if (can_put) begin
            res.write_valid = 1'b1;
            res.write_line  = 4'(cur.line_pos);
            res.write_col   = 8'(cur.column_pos);
            res.write_char  = data_byte;
            nxt.column_pos  = COL_W'(cur.column_pos + 1'b1);
          end
        end else begin
          // End of line: write the terminator and close the line.
          if (line_free) begin
            res.write_valid = 1'b1;
            res.write_line  = 4'(cur.line_pos);
            res.write_col   = 8'(cur.column_pos);
            res.write_char  = 8'd0;
            nxt.line_pos    = LINE_W'(cur.line_pos + 1'b1);
            if (cur.lines_stored < LINE_W'(LINE_SLOTS)) begin
              nxt.lines_stored = LINE_W'(cur.lines_stored + 1'b1);
            end
          end
          nxt.column_pos = '0;
          fsm_next       = ST_TEXT_LF;
        end
      end
      ST_TEXT_LF: begin
        if (data_byte == CH_LF) fsm_next = ST_LINE_START;
        else err = 1'b1;
      end
      ST_LINE_START: begin
        if (data_byte == CH_CR) fsm_next = ST_BLANK_LF;
        else if (!special_mode && data_byte == CH_PLUS) fsm_next = ST_TEXT;
        else err = 1'b1;
      end
      ST_BLANK_LF: begin
        if (data_byte == CH_LF) fsm_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (data_byte == CH_O) fsm_next = ST_O2_K;
        else if (data_byte == CH_E) fsm_next = ST_E2_R1;
        else err = 1'b1;
      end
      ST_E2_R1: begin
        if (data_byte == CH_R) fsm_next = ST_E2_R2;
        else err = 1'b1;
      end
      ST_E2_R2: begin
        if (data_byte == CH_R) fsm_next = ST_E2_O;
        else err = 1'b1;
      end
      ST_E2_O: begin
        if (data_byte == CH_O) fsm_next = ST_E2_R3;
        else err = 1'b1;
      end
      default: begin
        err = 1'b1;
      end
    endcase

    // Error recovery returns to idle and drops the partial line position.
    if (err) begin
      nxt.fsm         = ST_IDLE;
      nxt.line_pos    = '0;
      nxt.column_pos  = '0;
      res.status      = STATUS_ERROR;
      res.error_state = cur.fsm;
    end else begin
      nxt.fsm         = fsm_next;
      res.status      = (fsm_next == ST_DONE) ? STATUS_DONE : STATUS_BUSY;
      res.error_state = 5'd0;
    end

    res.response_ok = nxt.ok_flag;
    res.text_lines  = 5'(nxt.lines_stored);
  end

endmodule
